// ===== hdl/teq_pkg.sv =====
// Shared types and constants of the timed expiry queue.
package teq_pkg;

  localparam int CAPACITY_DEF  = 8;
  localparam int TAG_W         = 16;
  localparam int LIFE_W        = 16;
  localparam int KIND_W        = 2;
  localparam int IDX_W         = 3;
  localparam int CNT_OUT_W     = 4;
  localparam int LIMIT_W       = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic              occ;
    logic [TAG_W-1:0]  tag;
    logic [LIFE_W-1:0] life;
  } entry_t;

  typedef struct packed {
    logic              tick;
    logic [LIFE_W-1:0] elapsed;
    logic              step;
    logic              kill;
    logic              load;
    logic [TAG_W-1:0]  new_tag;
    logic [LIFE_W-1:0] new_life;
  } cell_ctrl_t;

endpackage

// ===== hdl/teq_cell.sv =====
// One queue slot: holds an entry, ages it and takes its younger neighbour when compacting.
module teq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  teq_pkg::cell_ctrl_t ctrl_i,
  input  teq_pkg::entry_t     next_i,
  input  logic                hole_below_i,
  output logic                hole_upto_o,
  output teq_pkg::entry_t     entry_o
);

  logic                       occ_q;
  logic [teq_pkg::TAG_W-1:0]  tag_q;
  logic [teq_pkg::LIFE_W-1:0] life_q;
  logic [teq_pkg::LIFE_W-1:0] life_sub;
  logic                       shift;

  assign hole_upto_o = hole_below_i | ~occ_q;
  assign shift       = ctrl_i.step & hole_upto_o;
  assign life_sub    = (life_q > ctrl_i.elapsed) ? (life_q - ctrl_i.elapsed) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (ctrl_i.load) begin
      occ_q <= 1'b1;
    end else if (shift) begin
      occ_q <= next_i.occ;
    end else if (ctrl_i.tick) begin
      occ_q <= occ_q & (life_sub != '0);
    end else if (ctrl_i.kill) begin
      occ_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tag_q  <= ctrl_i.new_tag;
      life_q <= ctrl_i.new_life;
    end else if (shift) begin
      tag_q  <= next_i.tag;
      life_q <= next_i.life;
    end else if (ctrl_i.tick) begin
      life_q <= life_sub;
    end
  end

  assign entry_o.occ  = occ_q;
  assign entry_o.tag  = tag_q;
  assign entry_o.life = life_q;

endmodule

// ===== hdl/timed_expiry_queue.sv =====
// Top level of the timed expiry queue: control sequencer around a row of slot cells.
// A read or unused kind goes straight to the result stage; an enqueue or tick first
// passes through compaction, which closes one gap per cycle, and an enqueue then
// appends its entry. One transaction is taken at a time, the next once the result is
// registered. A limit write holds off input until its trim has finished.
// Reset: async, low; empty, limit 3.
module timed_expiry_queue #(
  parameter int CAPACITY = teq_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transactions
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [teq_pkg::KIND_W-1:0]    kind_i,
  input  logic [teq_pkg::TAG_W-1:0]     entry_tag_i,
  input  logic [teq_pkg::LIFE_W-1:0]    duration_i,
  input  logic [teq_pkg::LIFE_W-1:0]    elapsed_i,
  input  logic [teq_pkg::IDX_W-1:0]     read_index_i,
  // result transactions
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [teq_pkg::CNT_OUT_W-1:0] active_count_o,
  output logic [teq_pkg::CNT_OUT_W-1:0] removed_count_o,
  output logic                          entry_valid_o,
  output logic [teq_pkg::TAG_W-1:0]     out_tag_o,
  output logic [teq_pkg::LIFE_W-1:0]    out_remaining_o,
  // limit register
  input  logic                          cfg_we_i,
  input  logic [teq_pkg::LIMIT_W-1:0]   cfg_wdata_i
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_DONE
  } state_e;

  state_e                         state_q;
  teq_pkg::kind_e                 kind_q;
  logic                           trim_q;
  logic [teq_pkg::TAG_W-1:0]      tag_q;
  logic [teq_pkg::LIFE_W-1:0]     dur_q;
  logic [teq_pkg::IDX_W-1:0]      ridx_q;
  logic [CW-1:0]                  len_q;
  logic [CW-1:0]                  start_q;
  logic [CW-1:0]                  removed_q;
  logic [teq_pkg::LIMIT_W-1:0]    max_active_q;
  logic                           trim_pend_q;

  logic                           out_valid_q;
  logic [teq_pkg::CNT_OUT_W-1:0]  active_count_q;
  logic [teq_pkg::CNT_OUT_W-1:0]  removed_count_q;
  logic                           entry_valid_q;
  logic [teq_pkg::TAG_W-1:0]      out_tag_q;
  logic [teq_pkg::LIFE_W-1:0]     out_remaining_q;

  teq_pkg::entry_t                cell_entry [CAPACITY];
  teq_pkg::cell_ctrl_t            cell_ctrl  [CAPACITY];
  logic [CAPACITY-1:0]            hole_upto;
  logic [CAPACITY-1:0]            hole_gap;

  logic                           accept;
  logic                           start_trim;
  logic                           hole_any;
  logic                           step;
  logic                           append;
  logic [CW-1:0]                  lim;
  logic [CW-1:0]                  kill_cnt;
  logic [CW-1:0]                  occ_cnt;
  logic [teq_pkg::IDX_W-1:0]      rd_pos;
  logic                           rd_valid;
  logic [teq_pkg::TAG_W-1:0]      rd_tag;
  logic [teq_pkg::LIFE_W-1:0]     rd_life;
  logic                           out_free;

  // Take input only when idle and no limit change is being written or waiting to be applied.
  assign in_ready_o = (state_q == ST_IDLE) & ~trim_pend_q & ~cfg_we_i;
  assign accept     = in_valid_i & in_ready_o;
  assign start_trim = (state_q == ST_IDLE) & trim_pend_q;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Effective limit: zero or beyond capacity means capacity.
  always_comb begin
    if (max_active_q == '0 || 32'(max_active_q) > CAPACITY) begin
      lim = CW'(CAPACITY);
    end else begin
      lim = CW'(max_active_q);
    end
  end

  // Number of oldest entries to drop: eviction on a full enqueue, or a limit trim.
  always_comb begin
    kill_cnt = '0;
    if (accept && kind_i == teq_pkg::KIND_ENQUEUE && len_q >= lim) begin
      kill_cnt = len_q - lim + CW'(1);
    end else if (start_trim && len_q > lim) begin
      kill_cnt = len_q - lim;
    end
  end

  // A gap inside the held span exists when an occupied slot sits above a hole.
  always_comb begin
    hole_gap[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      hole_gap[i] = hole_upto[i-1] & cell_entry[i].occ;
    end
  end

  // Occupied slots; once no gap is left they form the held span from slot 0,
  // which also covers entries dropped at the young end without any shift.
  always_comb begin
    occ_cnt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      occ_cnt = occ_cnt + CW'(cell_entry[i].occ);
    end
  end

  assign hole_any = |hole_gap;
  assign step     = (state_q == ST_COMPACT) & hole_any;
  assign append   = (state_q == ST_COMPACT) & ~hole_any & ~trim_q &
                    (kind_q == teq_pkg::KIND_ENQUEUE);

  // Row of cells; each hands its entry to the older neighbour on a compaction step.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    teq_pkg::entry_t next_entry;
    logic            hole_below;

    if (g == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = cell_entry[g+1];
    end

    if (g == 0) begin : g_head
      assign hole_below = 1'b0;
    end else begin : g_body
      assign hole_below = hole_upto[g-1];
    end

    assign cell_ctrl[g].tick     = accept & (kind_i == teq_pkg::KIND_TICK);
    assign cell_ctrl[g].elapsed  = elapsed_i;
    assign cell_ctrl[g].step     = step;
    assign cell_ctrl[g].kill     = 32'(kill_cnt) > g;
    assign cell_ctrl[g].load     = append & (32'(occ_cnt) == g);
    assign cell_ctrl[g].new_tag  = tag_q;
    assign cell_ctrl[g].new_life = dur_q;

    teq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[g]),
      .next_i       (next_entry),
      .hole_below_i (hole_below),
      .hole_upto_o  (hole_upto[g]),
      .entry_o      (cell_entry[g])
    );
  end

  // Report the addressed entry for a read, the oldest one otherwise.
  assign rd_pos   = (kind_q == teq_pkg::KIND_READ) ? ridx_q : '0;
  assign rd_valid = 32'(rd_pos) < 32'(len_q);

  always_comb begin
    rd_tag  = '0;
    rd_life = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(rd_pos) == i) begin
        rd_tag  = rd_tag | cell_entry[i].tag;
        rd_life = rd_life | cell_entry[i].life;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      kind_q          <= teq_pkg::KIND_NONE;
      trim_q          <= 1'b0;
      tag_q           <= '0;
      dur_q           <= '0;
      ridx_q          <= '0;
      len_q           <= '0;
      start_q         <= '0;
      removed_q       <= '0;
      max_active_q    <= teq_pkg::LIMIT_RESET;
      trim_pend_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      active_count_q  <= '0;
      removed_count_q <= '0;
      entry_valid_q   <= 1'b0;
      out_tag_q       <= '0;
      out_remaining_q <= '0;
    end else begin
      // Limit writes land at once; the trim runs when the sequencer is next idle.
      if (cfg_we_i) begin
        max_active_q <= cfg_wdata_i;
        trim_pend_q  <= 1'b1;
      end else if (start_trim) begin
        trim_pend_q  <= 1'b0;
      end

      // Drop the taken result unless a new one is loaded at the same edge.
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q    <= teq_pkg::kind_e'(kind_i);
            trim_q    <= 1'b0;
            tag_q     <= entry_tag_i;
            dur_q     <= duration_i;
            ridx_q    <= read_index_i;
            start_q   <= len_q;
            removed_q <= '0;
            if (kind_i == teq_pkg::KIND_ENQUEUE || kind_i == teq_pkg::KIND_TICK) begin
              state_q <= ST_COMPACT;
            end else begin
              state_q <= ST_DONE;
            end
          end else if (start_trim) begin
            trim_q  <= 1'b1;
            state_q <= ST_COMPACT;
          end
        end

        ST_COMPACT: begin
          if (hole_any) begin
            // close the lowest gap, one slot shorter
            len_q <= len_q - CW'(1);
          end else begin
            removed_q <= start_q - occ_cnt;
            len_q     <= append ? occ_cnt + CW'(1) : occ_cnt;
            state_q   <= trim_q ? ST_IDLE : ST_DONE;
          end
        end

        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q     <= 1'b1;
            active_count_q  <= teq_pkg::CNT_OUT_W'(len_q);
            removed_count_q <= teq_pkg::CNT_OUT_W'(removed_q);
            entry_valid_q   <= rd_valid;
            out_tag_q       <= rd_valid ? rd_tag : '0;
            out_remaining_q <= rd_valid ? rd_life : '0;
            state_q         <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign active_count_o  = active_count_q;
  assign removed_count_o = removed_count_q;
  assign entry_valid_o   = entry_valid_q;
  assign out_tag_o       = out_tag_q;
  assign out_remaining_o = out_remaining_q;

endmodule
